### hw/rtl/abf_pkg.sv
// Shared types, register indexes and arithmetic helpers for the alpha blitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package abf_pkg;

  typedef enum logic [2:0] {
    OC_READ  = 3'd0,
    OC_COPY  = 3'd1,
    OC_BLEND = 3'd2,
    OC_SKIP  = 3'd3,
    OC_CLIP  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    REG_DEST_W   = 3'd0,
    REG_DEST_H   = 3'd1,
    REG_SRC_W    = 3'd2,
    REG_SRC_H    = 3'd3,
    REG_PLACE_X  = 3'd4,
    REG_PLACE_Y  = 3'd5
  } reg_idx_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [15:0] ROUND_HALF  = 16'd127;
  localparam logic [8:0] SRC_DIM_MAX  = 9'd256;

  // Floor of x / 255 for any x below 65535.
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[16:8];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/alpha_blit_framebuffer.sv
// Alpha blitter owning a framebuffer of 32-bit RGBA pixels in one synchronous memory.
// Depends on abf_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_ready       mode, restart, source_pixel, read_col, read_row
//   out      source     out_valid / out_ready     pixel_out, outcome
//   config   APB slave  psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Each transaction passes through three steps: memory read, blend products, then write-back
// together with loading the output register, all on the one framebuffer memory.
// After reset the framebuffer is zeroed one pixel per cycle, all MAX_WIDTH*MAX_HEIGHT pixels,
// while in_ready stays low; configuration writes are taken throughout.
// A result waiting in the output register does not block acceptance; the next
// transaction waits at write-back until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module alpha_blit_framebuffer
  import abf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic        restart,
  input  wire logic [31:0] source_pixel,
  input  wire logic [7:0]  read_col,
  input  wire logic [7:0]  read_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_out,
  output logic [2:0]       outcome,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MEM, S_FIN} state_t;

  logic [8:0] dest_width;
  logic [8:0] dest_height;
  logic [8:0] source_width;
  logic [8:0] source_height;
  logic [9:0] place_x;
  logic [9:0] place_y;

  state_t         state;
  logic [AW-1:0]  clear_addr;
  logic [7:0]     col_cnt;
  logic [7:0]     row_cnt;
  outcome_t       it_oc;
  logic           it_zero;
  logic [31:0]    it_pix;
  logic [AW-1:0]  it_addr;
  logic [15:0]    acc [3];
  logic [15:0]    alpha_prod;

  logic [31:0]    mem [DEPTH];
  logic [31:0]    rd_data;

  logic           accept;
  logic           fin_go;
  logic [8:0]     w_eff;
  logic [8:0]     h_eff;
  logic [8:0]     sw_eff;
  logic [8:0]     sh_eff;
  logic [7:0]     col_eff;
  logic [7:0]     row_eff;
  logic [8:0]     col_inc;
  logic [8:0]     row_inc;
  logic [10:0]    tx;
  logic [10:0]    ty;
  logic           clipped;
  logic           rd_in_range;
  outcome_t       acc_oc;
  logic [AW-1:0]  acc_addr;
  logic [7:0]     src_a;
  logic [7:0]     inv_a;
  logic [31:0]    blend_pix;
  logic [8:0]     alpha_sum;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width    <= 9'd256;
      dest_height   <= 9'd256;
      source_width  <= 9'd1;
      source_height <= 9'd1;
      place_x       <= 10'd0;
      place_y       <= 10'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DEST_W:  dest_width    <= pwdata[8:0];
        REG_DEST_H:  dest_height   <= pwdata[8:0];
        REG_SRC_W:   source_width  <= pwdata[8:0];
        REG_SRC_H:   source_height <= pwdata[8:0];
        REG_PLACE_X: place_x       <= pwdata[9:0];
        REG_PLACE_Y: place_y       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DEST_W:  prdata = {23'd0, dest_width};
      REG_DEST_H:  prdata = {23'd0, dest_height};
      REG_SRC_W:   prdata = {23'd0, source_width};
      REG_SRC_H:   prdata = {23'd0, source_height};
      REG_PLACE_X: prdata = {22'd0, place_x};
      REG_PLACE_Y: prdata = {22'd0, place_y};
      default:     prdata = 32'd0;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    w_eff  = (32'(dest_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : dest_width;
    h_eff  = (32'(dest_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : dest_height;
    sw_eff = (source_width == 9'd0) ? 9'd1 :
             (source_width > SRC_DIM_MAX) ? SRC_DIM_MAX : source_width;
    sh_eff = (source_height == 9'd0) ? 9'd1 :
             (source_height > SRC_DIM_MAX) ? SRC_DIM_MAX : source_height;
    col_eff = restart ? 8'd0 : col_cnt;
    row_eff = restart ? 8'd0 : row_cnt;
    col_inc = {1'b0, col_eff} + 9'd1;
    row_inc = {1'b0, row_eff} + 9'd1;
    tx = {place_x[9], place_x} + {3'd0, col_eff};
    ty = {place_y[9], place_y} + {3'd0, row_eff};
    clipped = tx[10] || ty[10] || (tx[9:0] >= {1'b0, w_eff}) || (ty[9:0] >= {1'b0, h_eff});
    rd_in_range = ({1'b0, read_col} < w_eff) && ({1'b0, read_row} < h_eff);
    if (mode) begin
      acc_oc   = OC_READ;
      acc_addr = AW'(32'(read_row) * MAX_WIDTH + 32'(read_col));
    end else begin
      acc_addr = AW'(32'(ty[9:0]) * MAX_WIDTH + 32'(tx[9:0]));
      if (clipped) begin
        acc_oc = OC_CLIP;
      end else if (source_pixel[7:0] == ALPHA_OPAQUE) begin
        acc_oc = OC_COPY;
      end else if (source_pixel[7:0] == ALPHA_CLEAR) begin
        acc_oc = OC_SKIP;
      end else begin
        acc_oc = OC_BLEND;
      end
    end
  end

  assign src_a = it_pix[7:0];
  assign inv_a = ALPHA_OPAQUE - src_a;

  always_comb begin
    alpha_sum = {1'b0, src_a} + div255(alpha_prod);
    for (int i = 0; i < 3; i++) begin
      blend_pix[31 - 8*i -: 8] = 8'(div255(acc[i]));
    end
    blend_pix[7:0] = (alpha_sum > 9'd255) ? ALPHA_OPAQUE : alpha_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      col_cnt    <= 8'd0;
      row_cnt    <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            it_oc   <= acc_oc;
            it_zero <= mode && !rd_in_range;
            it_pix  <= source_pixel;
            it_addr <= acc_addr;
            state   <= S_MEM;
            if (!mode) begin
              if (col_inc >= sw_eff) begin
                col_cnt <= 8'd0;
                row_cnt <= (row_inc >= sh_eff) ? 8'd0 : row_inc[7:0];
              end else begin
                col_cnt <= col_inc[7:0];
                row_cnt <= row_eff;
              end
            end
          end
        end
        S_MEM: begin
          for (int i = 0; i < 3; i++) begin
            acc[i] <= 16'(it_pix[31 - 8*i -: 8] * src_a) +
                      16'(rd_data[31 - 8*i -: 8] * inv_a) + ROUND_HALF;
          end
          alpha_prod <= 16'(rd_data[7:0] * inv_a);
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            outcome   <= it_oc;
            case (it_oc)
              OC_READ:  pixel_out <= it_zero ? 32'd0 : rd_data;
              OC_COPY:  pixel_out <= it_pix;
              OC_BLEND: pixel_out <= blend_pix;
              OC_SKIP:  pixel_out <= rd_data;
              default:  pixel_out <= 32'd0;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = 32'd0;
    end else begin
      mem_we    = fin_go && (it_oc == OC_COPY || it_oc == OC_BLEND);
      mem_waddr = it_addr;
      mem_wdata = (it_oc == OC_COPY) ? it_pix : blend_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= mem[acc_addr];
    end
  end

`ifndef SYNTHESIS
  a_accept_to_mem: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MEM)
    else $error("accepted transaction did not start its memory read");

  a_write_only_hits: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |-> (it_oc == OC_COPY || it_oc == OC_BLEND))
    else $error("framebuffer written for a transaction that must not write");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> state == S_FIN)
    else $error("write-back left while the output register was full");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !(state == S_MEM))
    else $error("transaction started during the clearing pass");
`endif

endmodule
`default_nettype wire

### verif/alpha_blit_framebuffer_test.sv
// Self-checking testbench for the alpha blitter: it blits and reads pixels through the valid/ready
// channels, programs the placement over APB and checks every result against its own framebuffer.
// Depends on abf_pkg and alpha_blit_framebuffer.
`timescale 1ns / 1ps
module alpha_blit_framebuffer_test;
  import abf_pkg::*;

  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic        mode;
    logic        restart;
    logic [31:0] pix;
    logic [7:0]  col;
    logic [7:0]  row;
  } blit_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    outcome_t    oc;
  } blit_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic        restart = 1'b0;
  logic [31:0] source_pixel = '0;
  logic [7:0]  read_col = '0;
  logic [7:0]  read_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_out;
  logic [2:0]  outcome;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alpha_blit_framebuffer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .restart(restart), .source_pixel(source_pixel),
    .read_col(read_col), .read_row(read_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_out(pixel_out), .outcome(outcome),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit [31:0]         frame_model [0:65535];
  logic [8:0]        dest_w_cfg = 9'd256;
  logic [8:0]        dest_h_cfg = 9'd256;
  logic [8:0]        src_w_cfg = 9'd1;
  logic [8:0]        src_h_cfg = 9'd1;
  logic signed [9:0] place_x_cfg = '0;
  logic signed [9:0] place_y_cfg = '0;
  int                src_col = 0;
  int                src_row = 0;

  blit_item_t   pending_pixels [$];
  blit_result_t expected_pixels [$];
  logic         in_taken = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_extreme(int a, int b, int c, int d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  task automatic push_item(logic m, logic rs, logic [31:0] p, logic [7:0] c, logic [7:0] r);
    blit_item_t it;
    it = '{mode: m, restart: rs, pix: p, col: c, row: r};
    pending_pixels.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10) $display("Mismatch on %s: expected %h, got %h", what, want, got);
    mismatches++;
  endtask

  task automatic set_config(int dw, int dh, int sw, int sh, int px, int py);
    int       vals [6];
    reg_idx_t ri;
    vals = '{dw, dh, sw, sh, px, py};
    ri = REG_DEST_W;
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {ri, 2'b00};
      pwdata <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      case (ri)
        REG_DEST_W:  dest_w_cfg = 9'(vals[i]);
        REG_DEST_H:  dest_h_cfg = 9'(vals[i]);
        REG_SRC_W:   src_w_cfg = 9'(vals[i]);
        REG_SRC_H:   src_h_cfg = 9'(vals[i]);
        REG_PLACE_X: place_x_cfg = 10'(vals[i]);
        REG_PLACE_Y: place_y_cfg = 10'(vals[i]);
        default: ;
      endcase
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      ri = ri.next();
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  always @(negedge clk) begin
    blit_item_t it;
    logic       nv;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
    end else if (!in_valid || in_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pixels.size() > 0) begin
        it = pending_pixels.pop_front();
        {mode, restart, source_pixel, read_col, read_row} <= it;
        nv = 1'b1;
        gap_left = pick_gap();
      end
    end
    in_valid <= nv;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    int           w, h, sw, sh, tx, ty, a, sc, dc, na, k;
    int unsigned  addr;
    logic [31:0]  old, mixed;
    blit_result_t r;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      w = (dest_w_cfg > 9'd256) ? 256 : int'(dest_w_cfg);
      h = (dest_h_cfg > 9'd256) ? 256 : int'(dest_h_cfg);
      r.pixel = '0;
      if (mode) begin
        r.oc = OC_READ;
        if (int'(read_col) < w && int'(read_row) < h) r.pixel = frame_model[{read_row, read_col}];
      end else begin
        sw = (src_w_cfg == 9'd0) ? 1 : (src_w_cfg > 9'd256) ? 256 : int'(src_w_cfg);
        sh = (src_h_cfg == 9'd0) ? 1 : (src_h_cfg > 9'd256) ? 256 : int'(src_h_cfg);
        if (restart) begin
          src_col = 0;
          src_row = 0;
        end
        tx = int'(place_x_cfg) + src_col;
        ty = int'(place_y_cfg) + src_row;
        if (tx < 0 || ty < 0 || tx >= w || ty >= h) begin
          r.oc = OC_CLIP;
        end else begin
          addr = ty * 256 + tx;
          a = int'(source_pixel[7:0]);
          if (source_pixel[7:0] == ALPHA_OPAQUE) begin
            frame_model[addr] = source_pixel;
            r.oc = OC_COPY;
          end else if (source_pixel[7:0] == ALPHA_CLEAR) begin
            r.oc = OC_SKIP;
          end else begin
            old = frame_model[addr];
            for (k = 1; k < 4; k++) begin
              sc = int'(source_pixel[8*k +: 8]);
              dc = int'(old[8*k +: 8]);
              mixed[8*k +: 8] = 8'((sc * a + dc * (255 - a) + 127) / 255);
            end
            na = a + (int'(old[7:0]) * (255 - a)) / 255;
            mixed[7:0] = (na > 255) ? 8'd255 : 8'(na);
            frame_model[addr] = mixed;
            r.oc = OC_BLEND;
          end
          r.pixel = frame_model[addr];
        end
        src_col++;
        if (src_col >= sw) begin
          src_col = 0;
          src_row++;
          if (src_row >= sh) src_row = 0;
        end
      end
      expected_pixels.push_back(r);
    end
  end

  always @(posedge clk) begin
    blit_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with none pending, pixel_out", 32'hx, pixel_out);
      end else begin
        e = expected_pixels.pop_front();
        if (pixel_out !== e.pixel) report_mismatch("pixel_out", e.pixel, pixel_out);
        if (outcome !== e.oc) report_mismatch("outcome", 32'(e.oc), 32'(outcome));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          n, r, k, burst, dw, dh, sw, sh, px, py, we, swe, she;
    logic [31:0] pix;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Right and bottom edges, with a 4x2 source whose second row falls off the frame.
    set_config(256, 256, 4, 2, 254, 255);
    push_item(1'b0, 1'b1, 32'hA0B0C0FF, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'h12345600, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'h55667780, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'hFFFFFF01, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'hFFFFFFFF, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'h00000000, 8'd0, 8'd0);
    push_item(1'b0, 1'b1, 32'h00000001, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'hFFFFFFFE, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'h01020380, 8'd0, 8'd0);
    push_item(1'b0, 1'b1, 32'h00000080, 8'd0, 8'd0);
    push_item(1'b1, 1'b1, 32'hDEADBEEF, 8'd254, 8'd255);
    push_item(1'b1, 1'b0, 32'h00000000, 8'd255, 8'd255);
    push_item(1'b1, 1'b0, 32'hFFFFFFFF, 8'd0, 8'd0);
    push_item(1'b1, 1'b0, 32'h00000000, 8'd255, 8'd0);
    drain();

    // Zero-sized frame: everything clips and every read is zero.
    set_config(0, 0, 0, 0, 0, 0);
    push_item(1'b0, 1'b1, 32'h123456FF, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'h12345680, 8'd0, 8'd0);
    push_item(1'b1, 1'b0, 32'h0, 8'd0, 8'd0);
    push_item(1'b1, 1'b0, 32'h0, 8'd255, 8'd255);
    drain();

    // Oversized frame and source sizes saturate.
    set_config(511, 511, 511, 511, 255, 255);
    push_item(1'b0, 1'b1, 32'h0102037F, 8'd0, 8'd0);
    push_item(1'b0, 1'b0, 32'hFFFFFFFF, 8'd0, 8'd0);
    push_item(1'b1, 1'b0, 32'h0, 8'd255, 8'd255);
    push_item(1'b1, 1'b0, 32'h0, 8'd254, 8'd255);
    drain();

    set_config(256, 256, 256, 256, -512, 511);
    push_item(1'b0, 1'b1, 32'hCAFE00FF, 8'd0, 8'd0);
    push_item(1'b1, 1'b0, 32'h0, 8'd255, 8'd255);
    drain();

    for (int p = 0; p < 11; p++) begin
      idle_on = (p != 4);
      dw = ($urandom_range(0, 7) == 0) ? pick_extreme(0, 1, 256, 511) : $urandom_range(1, 256);
      dh = ($urandom_range(0, 7) == 0) ? pick_extreme(0, 1, 256, 511) : $urandom_range(1, 256);
      sw = ($urandom_range(0, 5) == 0) ? pick_extreme(0, 255, 256, 511) : $urandom_range(1, 10);
      sh = ($urandom_range(0, 5) == 0) ? pick_extreme(0, 255, 256, 511) : $urandom_range(1, 10);
      we = (dw > 256) ? 256 : dw;
      swe = (sw == 0) ? 1 : (sw > 256) ? 256 : sw;
      she = (sh == 0) ? 1 : (sh > 256) ? 256 : sh;
      px = ($urandom_range(0, 7) == 0) ? pick_extreme(-512, -256, 256, 511)
                                       : int'($urandom_range(0, we + 4)) - 6;
      we = (dh > 256) ? 256 : dh;
      py = ($urandom_range(0, 7) == 0) ? pick_extreme(-512, -256, 256, 511)
                                       : int'($urandom_range(0, we + 4)) - 6;
      set_config(dw, dh, sw, sh, px, py);
      n = 0;
      while (n < 115) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_item(1'($urandom), 1'($urandom), $urandom, 8'($urandom), 8'($urandom));
          n++;
        end else if (r < 30) begin
          if ($urandom_range(0, 9) < 7)
            push_item(1'b1, 1'($urandom), $urandom,
                      8'(px + int'($urandom_range(0, swe - 1))),
                      8'(py + int'($urandom_range(0, she - 1))));
          else
            push_item(1'b1, 1'($urandom), $urandom, 8'($urandom), 8'($urandom));
          n++;
        end else begin
          burst = (swe < 8) ? $urandom_range(1, 3 * swe) : $urandom_range(1, 12);
          for (k = 0; k < burst; k++) begin
            pix = $urandom;
            case ($urandom_range(0, 9))
              0, 1, 2: pix[7:0] = ALPHA_OPAQUE;
              3, 4:    pix[7:0] = ALPHA_CLEAR;
              5:       pix[7:0] = 8'(pick_extreme(1, 254, 127, 128));
              default: pix[7:0] = 8'($urandom_range(1, 254));
            endcase
            push_item(1'b0, (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 30) == 0),
                      pix, 8'($urandom), 8'($urandom));
            n++;
          end
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/abf_pkg.sv
hw/rtl/alpha_blit_framebuffer.sv
verif/alpha_blit_framebuffer_test.sv
